// ----- design/ubxnav_pkg.sv -----
// Shared types, constants and decode functions for the UBX navigation reply checker.
`default_nettype none

package ubxnav_pkg;

  localparam int MAX_FRAME_BYTES = 80;
  localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SLOTS           = 12;
  localparam int SLOT_W          = $clog2(SLOTS);
  localparam int POS_W           = 23;
  localparam int WORD_W          = 32;
  localparam int RECIP_W         = 29;
  localparam int PROD_W          = WORD_W + RECIP_W;
  localparam int DIV_SHIFT       = 38;

  // floor(x / 1000) == (x * DIV_RECIP) >> DIV_SHIFT for every 32-bit unsigned x.
  localparam logic [RECIP_W-1:0] DIV_RECIP = 29'h10624DD3;

  localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
  localparam logic [7:0] SYNC_CHAR_2 = 8'h62;
  localparam logic [7:0] CLASS_NAV   = 8'h01;
  localparam logic [7:0] ID_SOL      = 8'h06;
  localparam logic [7:0] ID_POSLLH   = 8'h02;
  localparam logic [7:0] ID_TIMEUTC  = 8'h21;

  localparam logic [IDX_W-1:0] LEN_SOL     = IDX_W'(56);
  localparam logic [IDX_W-1:0] LEN_POSLLH  = IDX_W'(32);
  localparam logic [IDX_W-1:0] LEN_TIMEUTC = IDX_W'(24);

  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINSEC_MAX = 8'd59;

  localparam int FLAG_FIX_OK = 0;
  localparam int FLAG_DGPS   = 1;
  localparam int HDR_SYNC    = 0;
  localparam int HDR_ID      = 1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_EVAL  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_SOL     = 2'd0,
    KIND_POSLLH  = 2'd1,
    KIND_TIMEUTC = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SYNC   = 3'd1,
    ST_BAD_ID     = 3'd2,
    ST_BAD_CKSUM  = 3'd3,
    ST_TIME_RANGE = 3'd4,
    ST_SHORT      = 3'd5
  } status_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  function automatic logic [IDX_W-1:0] sum_len(input kind_t kind);
    case (kind)
      KIND_POSLLH:  sum_len = LEN_POSLLH;
      KIND_TIMEUTC: sum_len = LEN_TIMEUTC;
      default:      sum_len = LEN_SOL;
    endcase
  endfunction

  function automatic logic [7:0] msg_id(input kind_t kind);
    case (kind)
      KIND_POSLLH:  msg_id = ID_POSLLH;
      KIND_TIMEUTC: msg_id = ID_TIMEUTC;
      default:      msg_id = ID_SOL;
    endcase
  endfunction

  // Which capture slot a frame position lands in, if any.
  function automatic slot_t slot_of(input kind_t kind, input logic [IDX_W-1:0] pos);
    slot_t s;
    s = '0;
    case (kind)
      KIND_POSLLH: begin
        if (pos >= IDX_W'(10) && pos <= IDX_W'(17)) begin
          s.hit = 1'b1;
          s.idx = SLOT_W'(pos - IDX_W'(10));
        end else if (pos >= IDX_W'(22) && pos <= IDX_W'(25)) begin
          s.hit = 1'b1;
          s.idx = SLOT_W'(pos - IDX_W'(14));
        end
      end
      KIND_TIMEUTC: begin
        if (pos >= IDX_W'(22) && pos <= IDX_W'(24)) begin
          s.hit = 1'b1;
          s.idx = SLOT_W'(pos - IDX_W'(22));
        end
      end
      default: begin
        if (pos == IDX_W'(16)) begin
          s.hit = 1'b1;
          s.idx = SLOT_W'(0);
        end else if (pos == IDX_W'(17)) begin
          s.hit = 1'b1;
          s.idx = SLOT_W'(1);
        end else if (pos == IDX_W'(53)) begin
          s.hit = 1'b1;
          s.idx = SLOT_W'(2);
        end
      end
    endcase
    slot_of = s;
  endfunction

endpackage

`default_nettype wire

// ----- design/ubxnav_in_if.sv -----
// Input channel: one beat per command (start, received byte or evaluate).
`default_nettype none

interface ubxnav_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] msg_kind;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output msg_kind, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input msg_kind, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- design/ubxnav_out_if.sv -----
// Output channel: one beat per evaluate, carrying the status and the held values.
`default_nettype none

interface ubxnav_out_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          status;
  logic [7:0]                          fix_type;
  logic                                dgps_used;
  logic [7:0]                          sat_count;
  logic signed [ubxnav_pkg::POS_W-1:0] longitude;
  logic signed [ubxnav_pkg::POS_W-1:0] latitude;
  logic signed [ubxnav_pkg::POS_W-1:0] altitude;
  logic [7:0]                          hours;
  logic [7:0]                          minutes;
  logic [7:0]                          seconds;

  modport source (output valid, output status, output fix_type, output dgps_used,
                  output sat_count, output longitude, output latitude, output altitude,
                  output hours, output minutes, output seconds, input ready);
  modport sink   (input valid, input status, input fix_type, input dgps_used,
                  input sat_count, input longitude, input latitude, input altitude,
                  input hours, input minutes, input seconds, output ready);
endinterface

`default_nettype wire

// ----- design/ubxnav_top.sv -----
// Top level of the UBX navigation reply checker: byte tracking, checksum, capture and evaluation.
//
// The block takes one command beat at a time on the item channel: start a new reply,
// one received byte, or evaluate. Only an evaluate beat produces a result beat.
// A result beat carries the status and every held value.
// The result of an evaluate is offered in the cycle after the evaluate beat
// is accepted. Start and byte beats update the frame state at their accepting edge.
// Throughput: one item beat per cycle while no result waits on a stalled receiver.
// Back-to-back evaluates give one result per cycle while the receiver keeps ready high.
// The position words pass through a three-register divide by 1000 that runs on the
// captured bytes. The last position byte passes the capture, mag, prod and quot registers;
// it sits at frame position 25, nine positions before the first checksum byte.
// Reset clears the byte count, the checksum, the header flags and every held value,
// and leaves no result pending. The captured payload bytes are not reset.
// When a result waits on a stalled receiver, item.ready stays low until that beat is taken.
`default_nettype none

module ubx_nav_response_checker_top (
  input  logic            clk,
  input  logic            rst,
  ubxnav_in_if.sink       item,
  ubxnav_out_if.source    result
);
  import ubxnav_pkg::*;

  logic                    in_fire;
  opcode_t                 opcode;
  logic [IDX_W-1:0]        byte_index;
  kind_t                   expected_kind;
  logic [7:0]              sum_a;
  logic [7:0]              sum_b;
  logic [1:0]              header_flags;
  logic                    checksum_ok;
  logic [7:0]              raw_bytes [SLOTS];
  logic [7:0]              held_fix_type;
  logic                    held_dgps;
  logic [7:0]              held_sats;
  logic signed [POS_W-1:0] held_lon;
  logic signed [POS_W-1:0] held_lat;
  logic signed [POS_W-1:0] held_alt;
  logic [7:0]              held_hours;
  logic [7:0]              held_minutes;
  logic [7:0]              held_seconds;
  logic                    out_valid;
  status_t                 status;

  logic [IDX_W-1:0]        frame_len;
  logic                    byte_take;
  logic [7:0]              sum_a_next;
  logic [7:0]              sum_b_next;
  logic [1:0]              header_flags_next;
  logic                    checksum_ok_next;
  slot_t                   slot;
  status_t                 status_next;
  logic signed [POS_W-1:0] div_lon;
  logic signed [POS_W-1:0] div_lat;
  logic signed [POS_W-1:0] div_alt;

  assign opcode     = opcode_t'(item.opcode);
  assign item.ready = !out_valid || result.ready;
  assign in_fire    = item.valid && item.ready;

  assign frame_len  = sum_len(expected_kind);
  assign byte_take  = in_fire && (opcode == OP_BYTE) && (byte_index < IDX_W'(MAX_FRAME_BYTES));
  assign slot       = slot_of(expected_kind, byte_index);

  // The divides run continuously on the captured words; the last position byte
  // sits well ahead of the checksum, so they have settled before any good evaluate.
  ubxnav_div1000 u_div_lon (
    .clk  (clk),
    .word ({raw_bytes[3], raw_bytes[2], raw_bytes[1], raw_bytes[0]}),
    .quot (div_lon)
  );

  ubxnav_div1000 u_div_lat (
    .clk  (clk),
    .word ({raw_bytes[7], raw_bytes[6], raw_bytes[5], raw_bytes[4]}),
    .quot (div_lat)
  );

  ubxnav_div1000 u_div_alt (
    .clk  (clk),
    .word ({raw_bytes[11], raw_bytes[10], raw_bytes[9], raw_bytes[8]}),
    .quot (div_alt)
  );

  always_comb begin
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    header_flags_next = header_flags;
    checksum_ok_next  = checksum_ok;
    if (byte_index == IDX_W'(0) && item.rx_byte != SYNC_CHAR_1) begin
      header_flags_next[HDR_SYNC] = 1'b1;
    end
    if (byte_index == IDX_W'(1) && item.rx_byte != SYNC_CHAR_2) begin
      header_flags_next[HDR_SYNC] = 1'b1;
    end
    if (byte_index == IDX_W'(2) && item.rx_byte != CLASS_NAV) begin
      header_flags_next[HDR_ID] = 1'b1;
    end
    if (byte_index == IDX_W'(3) && item.rx_byte != msg_id(expected_kind)) begin
      header_flags_next[HDR_ID] = 1'b1;
    end
    if (byte_index >= IDX_W'(2) && byte_index < frame_len + IDX_W'(2)) begin
      sum_a_next = sum_a + item.rx_byte;
      sum_b_next = sum_b + sum_a_next;
    end else if (byte_index == frame_len + IDX_W'(2)) begin
      checksum_ok_next = (item.rx_byte == sum_a);
    end else if (byte_index == frame_len + IDX_W'(3)) begin
      checksum_ok_next = checksum_ok && (item.rx_byte == sum_b);
    end
  end

  always_comb begin
    if (byte_index < frame_len + IDX_W'(4)) begin
      status_next = ST_SHORT;
    end else if (!checksum_ok) begin
      status_next = ST_BAD_CKSUM;
    end else if (header_flags[HDR_ID]) begin
      status_next = ST_BAD_ID;
    end else if (header_flags[HDR_SYNC]) begin
      status_next = ST_BAD_SYNC;
    end else if (expected_kind == KIND_TIMEUTC &&
                 (raw_bytes[0] > HOUR_MAX || raw_bytes[1] > MINSEC_MAX ||
                  raw_bytes[2] > MINSEC_MAX)) begin
      status_next = ST_TIME_RANGE;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      expected_kind <= KIND_SOL;
      sum_a         <= '0;
      sum_b         <= '0;
      header_flags  <= '0;
      checksum_ok   <= 1'b0;
      held_fix_type <= '0;
      held_dgps     <= 1'b0;
      held_sats     <= '0;
      held_lon      <= '0;
      held_lat      <= '0;
      held_alt      <= '0;
      held_hours    <= '0;
      held_minutes  <= '0;
      held_seconds  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire && opcode == OP_EVAL) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        case (opcode)
          OP_START: begin
            expected_kind <= (item.msg_kind > 2'(KIND_TIMEUTC)) ? KIND_SOL
                                                                : kind_t'(item.msg_kind);
            byte_index    <= '0;
            sum_a         <= '0;
            sum_b         <= '0;
            header_flags  <= '0;
            checksum_ok   <= 1'b0;
          end
          OP_BYTE: begin
            if (byte_take) begin
              byte_index   <= byte_index + IDX_W'(1);
              sum_a        <= sum_a_next;
              sum_b        <= sum_b_next;
              header_flags <= header_flags_next;
              checksum_ok  <= checksum_ok_next;
            end
          end
          OP_EVAL: begin
            case (expected_kind)
              KIND_POSLLH: begin
                if (status_next == ST_OK) begin
                  held_lon <= div_lon;
                  held_lat <= div_lat;
                  held_alt <= div_alt;
                end
              end
              KIND_TIMEUTC: begin
                // Time bytes are stored even when they fail the range check.
                if (status_next == ST_OK || status_next == ST_TIME_RANGE) begin
                  held_hours   <= raw_bytes[0];
                  held_minutes <= raw_bytes[1];
                  held_seconds <= raw_bytes[2];
                end
              end
              default: begin
                if (status_next == ST_OK) begin
                  if (raw_bytes[1][FLAG_FIX_OK]) begin
                    held_dgps     <= raw_bytes[1][FLAG_DGPS];
                    held_fix_type <= raw_bytes[0];
                  end else begin
                    held_fix_type <= '0;
                  end
                  held_sats <= raw_bytes[2];
                end else begin
                  held_fix_type <= '0;
                end
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && slot.hit) begin
      raw_bytes[slot.idx] <= item.rx_byte;
    end
    if (in_fire && opcode == OP_EVAL) begin
      status <= status_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.status    = status;
  assign result.fix_type  = held_fix_type;
  assign result.dgps_used = held_dgps;
  assign result.sat_count = held_sats;
  assign result.longitude = held_lon;
  assign result.latitude  = held_lat;
  assign result.altitude  = held_alt;
  assign result.hours     = held_hours;
  assign result.minutes   = held_minutes;
  assign result.seconds   = held_seconds;

`ifndef NO_ASSERTIONS
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_W'(MAX_FRAME_BYTES))
    else $error("byte count ran past the frame limit");

  a_eval_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (in_fire && opcode == OP_EVAL) |=> out_valid)
    else $error("evaluate beat produced no result beat");

  a_beat_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire && opcode == OP_EVAL))
    else $error("result beat appeared without an evaluate");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_TIME_RANGE) |->
      (held_hours > HOUR_MAX || held_minutes > MINSEC_MAX || held_seconds > MINSEC_MAX))
    else $error("time range error reported with an in-range time");
`endif

endmodule

`default_nettype wire

// ----- design/ubxnav_div1000.sv -----
// Three-stage pipelined signed divide by 1000, truncating toward zero.
`default_nettype none

module ubxnav_div1000 (
  input  logic                                clk,
  input  logic [ubxnav_pkg::WORD_W-1:0]       word,
  output logic signed [ubxnav_pkg::POS_W-1:0] quot
);
  import ubxnav_pkg::*;

  logic              neg1;
  logic [WORD_W-1:0] mag;
  logic              neg2;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  q_mag;

  // Work on the magnitude so that the floor of the reciprocal product truncates toward zero.
  always_ff @(posedge clk) begin
    neg1 <= word[WORD_W-1];
    mag  <= word[WORD_W-1] ? (~word + WORD_W'(1)) : word;
    neg2 <= neg1;
    prod <= PROD_W'(mag) * PROD_W'(DIV_RECIP);
    quot <= neg2 ? $signed(~q_mag + POS_W'(1)) : $signed(q_mag);
  end

  assign q_mag = prod[DIV_SHIFT +: POS_W];

endmodule

`default_nettype wire
